[rtl/dcrc_pkg.sv]
// ----------------------------------------------------------------------------
// dcrc_pkg
// Shared types, constants and the control store of the decimal-coded radix
// converter: field widths, status codes, step addresses and reciprocal table.
// ----------------------------------------------------------------------------
package dcrc_pkg;

   // Field and datapath widths
   localparam int VALUE_BITS = 31;
   localparam int MAX_DIGITS = 31;
   localparam int RADIX_W    = 4;
   localparam int DIGIT_W    = 4;
   localparam int REM_W      = 5;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int PROD_W     = 2 * VALUE_BITS;
   localparam int STEP_W     = 3;

   // Stream widths: fields packed from bit 0 up, padded to whole bytes
   localparam int REQ_FIELDS = 1 + RADIX_W + VALUE_BITS;
   localparam int REQ_W      = ((REQ_FIELDS + 7) / 8) * 8;
   localparam int RSP_FIELDS = VALUE_BITS + 2;
   localparam int RSP_W      = ((RSP_FIELDS + 7) / 8) * 8;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
   localparam logic [RADIX_W-1:0]    DEC_BASE  = RADIX_W'(10);
   localparam logic [RADIX_W-1:0]    RADIX_LO  = RADIX_W'(2);
   localparam logic [RADIX_W-1:0]    RADIX_HI  = RADIX_W'(10);

   // Scale of the reciprocal: 2^VALUE_BITS
   localparam logic [VALUE_BITS:0] RCP_ONE = (VALUE_BITS + 1)'(1) << VALUE_BITS;

   // Function codes
   localparam logic FUNC_TO_CODED   = 1'b0;
   localparam logic FUNC_FROM_CODED = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_OVF   = 2'd1,
      ST_RADIX = 2'd2
   } status_type;

   // Program addresses
   localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_MUL  = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_DIV  = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_ACC  = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_FIN  = STEP_W'(4);

   typedef enum logic [1:0] {
      HOLD_NONE  = 2'd0,
      HOLD_INPUT = 2'd1,
      HOLD_SLOT  = 2'd2
   } hold_type;

   typedef enum logic [1:0] {
      BR_NONE      = 2'd0,
      BR_BAD_RADIX = 2'd1,
      BR_LOOP_END  = 2'd2
   } br_type;

   // One control word of the program
   typedef struct packed {
      hold_type          hold;
      br_type            br;
      logic [STEP_W-1:0] target;
      logic [STEP_W-1:0] next;
      logic              load;
      logic              mul;
      logic              div;
      logic              acc;
      logic              emit;
   } ucode_type;

   // Datapath enables, already qualified by the handshakes
   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic acc;
      logic emit;
   } ctrl_type;

   // Conditions fed back to the sequencer
   typedef struct packed {
      logic bad_radix;
      logic loop_end;
      logic slot_free;
   } flags_type;

   // Control store
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type cw;
      cw = '{hold: HOLD_NONE, br: BR_NONE, target: STEP_IDLE, next: STEP_IDLE,
             load: 1'b0, mul: 1'b0, div: 1'b0, acc: 1'b0, emit: 1'b0};
      case (step)
         STEP_IDLE: begin
            cw.hold   = HOLD_INPUT;
            cw.br     = BR_BAD_RADIX;
            cw.target = STEP_FIN;
            cw.next   = STEP_MUL;
            cw.load   = 1'b1;
         end
         STEP_MUL: begin
            cw.next = STEP_DIV;
            cw.mul  = 1'b1;
         end
         STEP_DIV: begin
            cw.next = STEP_ACC;
            cw.div  = 1'b1;
         end
         STEP_ACC: begin
            cw.br     = BR_LOOP_END;
            cw.target = STEP_FIN;
            cw.next   = STEP_DIV;
            cw.mul    = 1'b1;
            cw.acc    = 1'b1;
         end
         STEP_FIN: begin
            cw.hold = HOLD_SLOT;
            cw.next = STEP_IDLE;
            cw.emit = 1'b1;
         end
         default: begin
            cw.next = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

   // floor(2^VALUE_BITS / d); the quotient estimate is then exact or one low
   function automatic logic [VALUE_BITS-1:0] recip(input logic [RADIX_W-1:0] d);
      logic [VALUE_BITS-1:0] r;
      case (d)
         RADIX_W'(2):  r = VALUE_BITS'(RCP_ONE / 2);
         RADIX_W'(3):  r = VALUE_BITS'(RCP_ONE / 3);
         RADIX_W'(4):  r = VALUE_BITS'(RCP_ONE / 4);
         RADIX_W'(5):  r = VALUE_BITS'(RCP_ONE / 5);
         RADIX_W'(6):  r = VALUE_BITS'(RCP_ONE / 6);
         RADIX_W'(7):  r = VALUE_BITS'(RCP_ONE / 7);
         RADIX_W'(8):  r = VALUE_BITS'(RCP_ONE / 8);
         RADIX_W'(9):  r = VALUE_BITS'(RCP_ONE / 9);
         RADIX_W'(10): r = VALUE_BITS'(RCP_ONE / 10);
         default:      r = '0;
      endcase
      return r;
   endfunction

endpackage

[rtl/decimal_coded_radix_converter.sv]
// ----------------------------------------------------------------------------
// decimal_coded_radix_converter
// Converts between a binary integer and base-b digits written as decimal
// digits, one result transfer per request transfer.
// ----------------------------------------------------------------------------
//  channel  dir  ports                     tdata fields (bit 0 up)
//  req      in   req_tvalid/tready/tdata   func[0] radix[4:1] value[35:5]
//  rsp      out  rsp_tvalid/tready/tdata   result[30:0] status[32:31]
//
//  An item passes through the sequencer steps in order: the accept step,
//  one setup multiply, then for each of the n digit positions visited
//  (1 to 31) two steps (quotient correction, then weighting together with
//  the next reciprocal multiply), then the result step. A bad radix jumps
//  from the accept step straight to the result step.
//  Reset (synchronous) returns the step counter to idle and empties the
//  result register. A stalled rsp holds the sequencer at its final step;
//  req is taken again as soon as the result is loaded.
// ----------------------------------------------------------------------------
module decimal_coded_radix_converter import dcrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // func, radix, value
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // result, status
);

   ctrl_type              ctrl;
   flags_type             flags;
   logic [VALUE_BITS-1:0] rsp_result;
   status_type            rsp_status;

   dcrc_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .ctrl       (ctrl)
   );

   dcrc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .flags      (flags),
      .req_func   (req_tdata[0]),
      .req_radix  (req_tdata[RADIX_W:1]),
      .req_value  (req_tdata[RADIX_W+VALUE_BITS:RADIX_W+1]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result),
      .rsp_status (rsp_status)
   );

   // Pack the result transfer, zero padded
   assign rsp_tdata = RSP_W'({rsp_status, rsp_result});

endmodule

[rtl/dcrc_sequencer.sv]
// ----------------------------------------------------------------------------
// dcrc_sequencer
// Step counter and control store; qualifies each control word with the
// stream handshakes and takes conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module dcrc_sequencer import dcrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucode_type         cw;
   logic              go;
   logic              taken;

   // Fetch the control word of the current step
   assign cw = ucode_rom(step_ff);

   assign req_tready = (cw.hold == HOLD_INPUT);

   // Decide whether the step completes this cycle
   always_comb begin
      case (cw.hold)
         HOLD_NONE:  go = 1'b1;
         HOLD_INPUT: go = req_tvalid;
         HOLD_SLOT:  go = flags.slot_free;
         default:    go = 1'b1;
      endcase
   end

   // Evaluate the jump condition
   always_comb begin
      case (cw.br)
         BR_NONE:      taken = 1'b0;
         BR_BAD_RADIX: taken = flags.bad_radix;
         BR_LOOP_END:  taken = flags.loop_end;
         default:      taken = 1'b0;
      endcase
   end

   // Pick the next step
   always_comb begin
      step_in = step_ff;
      if (go) begin
         step_in = taken ? cw.target : cw.next;
      end
   end

   // Gate datapath enables with the handshake
   assign ctrl.load = cw.load & go;
   assign ctrl.mul  = cw.mul & go;
   assign ctrl.div  = cw.div & go;
   assign ctrl.acc  = cw.acc & go;
   assign ctrl.emit = cw.emit & go;

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_FIN)
      else $error("step counter left the program");

   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |=> step_ff == STEP_IDLE)
      else $error("sequencer did not return to idle after a result");

   a_bad_radix_skip: assert property (@(posedge clock) disable iff (reset)
      ctrl.load && flags.bad_radix |=> step_ff == STEP_FIN)
      else $error("bad radix did not jump straight to the result step");

endmodule

[rtl/dcrc_datapath.sv]
// ----------------------------------------------------------------------------
// dcrc_datapath
// Digit extraction by reciprocal multiply, weighted accumulation with
// overflow checks, and the result register.
// ----------------------------------------------------------------------------
module dcrc_datapath import dcrc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_type              ctrl,
   output flags_type             flags,
   input  logic                  req_func,
   input  logic [RADIX_W-1:0]    req_radix,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VALUE_BITS-1:0] rsp_result,
   output status_type            rsp_status
);

   localparam int TERM_W = VALUE_BITS + DIGIT_W;
   localparam int PNXT_W = VALUE_BITS + RADIX_W;

   logic [VALUE_BITS-1:0] q_ff;
   logic [VALUE_BITS-1:0] p_ff;
   logic [VALUE_BITS-1:0] acc_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [VALUE_BITS-1:0] recip_ff;
   logic [RADIX_W-1:0]    div_ff;
   logic [RADIX_W-1:0]    mul_ff;
   logic [DIGIT_W-1:0]    digit_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  ovf_ff;
   logic                  bad_ff;
   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_result_ff;
   status_type            rsp_status_ff;

   logic                  bad_in;
   logic [RADIX_W-1:0]    div_in;
   logic [RADIX_W-1:0]    mul_in;
   logic [VALUE_BITS-1:0] qhat;
   logic [REM_W-1:0]      rem_raw;
   logic                  rem_fix;
   logic [DIGIT_W-1:0]    digit_in;
   logic [VALUE_BITS-1:0] quot_in;
   logic [TERM_W-1:0]     term;
   logic [VALUE_BITS-1:0] room;
   logic                  acc_ovf;
   logic [PNXT_W-1:0]     p_next;
   logic                  p_ovf;
   logic                  last_pos;
   logic                  q_zero;
   logic                  ovf_in;

   // Decode the incoming transfer: divisor and weight base by function
   always_comb begin
      bad_in = !(req_radix inside {[RADIX_LO:RADIX_HI]});
      if (req_func == FUNC_FROM_CODED) begin
         div_in = DEC_BASE;
         mul_in = req_radix;
      end else begin
         div_in = req_radix;
         mul_in = DEC_BASE;
      end
   end

   // Quotient estimate; remainder lives below 2*div, so low bits suffice
   always_comb begin
      qhat     = prod_ff[PROD_W-1:VALUE_BITS];
      rem_raw  = q_ff[REM_W-1:0] - REM_W'(qhat[REM_W-1:0] * REM_W'(div_ff));
      rem_fix  = rem_raw >= REM_W'(div_ff);
      digit_in = rem_fix ? DIGIT_W'(rem_raw - REM_W'(div_ff)) : DIGIT_W'(rem_raw);
      quot_in  = rem_fix ? qhat + VALUE_BITS'(1) : qhat;
   end

   // Weight the digit and check both overflow limits
   always_comb begin
      term     = TERM_W'(digit_ff) * TERM_W'(p_ff);
      room     = VALUE_MAX - acc_ff;
      acc_ovf  = term > TERM_W'(room);
      p_next   = PNXT_W'(mul_ff) * PNXT_W'(p_ff);
      p_ovf    = |p_next[PNXT_W-1:VALUE_BITS];
      last_pos = cnt_ff == CNT_W'(MAX_DIGITS - 1);
      q_zero   = q_ff == '0;
      ovf_in   = acc_ovf || (!q_zero && (p_ovf || last_pos));
   end

   assign flags.bad_radix = bad_in;
   assign flags.loop_end  = acc_ovf || q_zero || p_ovf || last_pos;
   assign flags.slot_free = !rsp_valid_ff || rsp_tready;

   // Working registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         q_ff     <= req_value;
         p_ff     <= VALUE_BITS'(1);
         acc_ff   <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         bad_ff   <= bad_in;
         div_ff   <= div_in;
         mul_ff   <= mul_in;
         recip_ff <= recip(div_in);
      end
      if (ctrl.mul) begin
         prod_ff <= PROD_W'(q_ff) * PROD_W'(recip_ff);
      end
      if (ctrl.div) begin
         q_ff     <= quot_in;
         digit_ff <= digit_in;
      end
      if (ctrl.acc) begin
         acc_ff <= acc_ff + term[VALUE_BITS-1:0];
         p_ff   <= p_next[VALUE_BITS-1:0];
         cnt_ff <= cnt_ff + CNT_W'(1);
         ovf_ff <= ovf_in;
      end
   end

   // Result register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         if (bad_ff) begin
            rsp_result_ff <= '0;
            rsp_status_ff <= ST_RADIX;
         end else if (ovf_ff) begin
            rsp_result_ff <= VALUE_MAX;
            rsp_status_ff <= ST_OVF;
         end else begin
            rsp_result_ff <= acc_ff;
            rsp_status_ff <= ST_OK;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

   a_digit_below_base: assert property (@(posedge clock) disable iff (reset)
      ctrl.div |=> digit_ff < div_ff)
      else $error("extracted digit not below the divisor");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ctrl.div |-> rem_raw < REM_W'(2 * div_ff))
      else $error("quotient estimate off by more than one");

   a_weight_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctrl.acc |-> p_ff != '0)
      else $error("digit weight lost");

endmodule

[sim/decimal_coded_radix_converter_test.sv]
// ----------------------------------------------------------------------------
// decimal_coded_radix_converter_test
// Drives request transfers into the radix converter and checks every result
// transfer against a cycle-free prediction of the conversion, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module decimal_coded_radix_converter_test import dcrc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CYCLE_LIMIT  = 1_000_000;
   localparam int  RANDOM_ITEMS = 1800;
   localparam int  QUIET_TAIL   = 200;
   localparam int  DRAIN_CYCLES = 2 * MAX_DIGITS + 16;

   // One predicted conversion
   typedef struct {
      logic [VALUE_BITS-1:0] result;
      status_type            status;
   } conversion_type;

   // Predicts conversions and holds them until the matching result arrives
   class conversion_scoreboard;
      conversion_type pending_conversions[$];
      int             failures;

      function new();
         failures = 0;
      endfunction

      // Split the value into digits of one base and weight them by another
      function conversion_type convert(logic func, logic [RADIX_W-1:0] radix,
                                       logic [VALUE_BITS-1:0] value);
         conversion_type   c;
         longint unsigned  ceiling;
         longint unsigned  divisor;
         longint unsigned  weight_base;
         longint unsigned  rest;
         longint unsigned  weight;
         longint unsigned  sum;
         longint unsigned  digit;
         c.result = '0;
         c.status = ST_OK;
         if (radix < RADIX_LO || radix > RADIX_HI) begin
            c.status = ST_RADIX;
            return c;
         end
         ceiling     = longint'(VALUE_MAX);
         divisor     = (func == FUNC_TO_CODED) ? longint'(radix) : longint'(DEC_BASE);
         weight_base = (func == FUNC_TO_CODED) ? longint'(DEC_BASE) : longint'(radix);
         rest        = longint'(value);
         weight      = 1;
         sum         = 0;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digit = rest % divisor;
            rest  = rest / divisor;
            if (digit != 0) begin
               if (digit > (ceiling - sum) / weight) begin
                  c.result = VALUE_MAX;
                  c.status = ST_OVF;
                  return c;
               end
               sum += digit * weight;
            end
            if (rest == 0)
               break;
            if (weight > ceiling / weight_base) begin
               c.result = VALUE_MAX;
               c.status = ST_OVF;
               return c;
            end
            weight *= weight_base;
         end
         // Saturate when digit positions run out
         if (rest != 0) begin
            c.result = VALUE_MAX;
            c.status = ST_OVF;
            return c;
         end
         c.result = sum[VALUE_BITS-1:0];
         return c;
      endfunction

      function void note_request(logic [REQ_W-1:0] word);
         pending_conversions.push_back(convert(word[0], word[RADIX_W:1],
                                               word[RADIX_W+1 +: VALUE_BITS]));
      endfunction

      function void check_response(logic [RSP_W-1:0] word);
         conversion_type want;
         logic [1:0]     got_status;
         if (pending_conversions.size() == 0) begin
            $error("result transfer with no request outstanding: %h", word);
            failures++;
            return;
         end
         want       = pending_conversions.pop_front();
         got_status = word[VALUE_BITS +: 2];
         if (word[VALUE_BITS-1:0] !== want.result) begin
            $error("result: expected %0d, actual %0d", want.result, word[VALUE_BITS-1:0]);
            failures++;
         end
         if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            failures++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // func, radix, value
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // result, status

   conversion_scoreboard board;
   bit                   req_gaps_on;
   bit                   rsp_stalls_on;
   int                   cycles;
   int                   stall_left;

   decimal_coded_radix_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Known values from time zero
   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      cycles        = 0;
      stall_left    = 0;
      board         = new();
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("decimal_coded_radix_converter: mismatch");
         $finish;
      end
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata);
      end
   end

   // Stall the result channel in random bursts; drop a burst when stalls stop
   always @(negedge clock) begin
      if (!rsp_stalls_on) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Present one request and hold it until the transfer
   task automatic send_request(input logic func, input logic [RADIX_W-1:0] radix,
                               input logic [VALUE_BITS-1:0] value);
      logic [REQ_W-1:0] word;
      word                          = '0;
      word[0]                       = func;
      word[RADIX_W:1]               = radix;
      word[RADIX_W+1 +: VALUE_BITS] = value;
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Value with a random bit length, so small and large magnitudes both occur
   function automatic logic [VALUE_BITS-1:0] random_binary();
      int              len;
      longint unsigned raw;
      len = $urandom_range(0, VALUE_BITS);
      raw = {$urandom, $urandom};
      return VALUE_BITS'(raw & ((64'd1 << len) - 1));
   endfunction

   // Decimal digit string, mostly with digits below the base
   function automatic logic [VALUE_BITS-1:0] random_coded(input logic [RADIX_W-1:0] radix);
      longint unsigned sum;
      longint unsigned weight;
      int              count;
      int              top;
      sum    = 0;
      weight = 1;
      count  = $urandom_range(1, 10);
      top    = (radix >= RADIX_LO && radix <= RADIX_HI) ? radix - 1 : 9;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0)
            sum += weight * $urandom_range(0, 9);
         else
            sum += weight * $urandom_range(0, top);
         weight *= 10;
      end
      return VALUE_BITS'(sum % (longint'(VALUE_MAX) + 1));
   endfunction

   initial begin
      logic                  func;
      logic [RADIX_W-1:0]    radix;
      logic [VALUE_BITS-1:0] value;
      int                    pick;

      // Hold reset, then release it between clock edges
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero, full scale, overflow, bad bases, oversized digits
      send_request(FUNC_TO_CODED,   RADIX_LO, '0);
      send_request(FUNC_FROM_CODED, RADIX_LO, '0);
      send_request(FUNC_TO_CODED,   RADIX_HI, VALUE_MAX);
      send_request(FUNC_FROM_CODED, RADIX_HI, VALUE_MAX);
      send_request(FUNC_TO_CODED,   RADIX_LO, VALUE_MAX);
      send_request(FUNC_TO_CODED,   RADIX_LO, 31'd1023);
      send_request(FUNC_TO_CODED,   RADIX_LO, 31'd1024);
      send_request(FUNC_FROM_CODED, RADIX_LO, 31'd1111111111);
      send_request(FUNC_FROM_CODED, RADIX_LO, 31'd99);
      send_request(FUNC_FROM_CODED, 4'd9,     VALUE_MAX);
      send_request(FUNC_TO_CODED,   4'd9,     VALUE_MAX);
      send_request(FUNC_TO_CODED,   4'd3,     VALUE_MAX);
      send_request(FUNC_TO_CODED,   4'd4,     VALUE_MAX);
      send_request(FUNC_TO_CODED,   4'd7,     VALUE_MAX);
      send_request(FUNC_FROM_CODED, 4'd7,     31'd6543210);
      send_request(FUNC_FROM_CODED, RADIX_HI, 31'd1000000000);
      send_request(FUNC_TO_CODED,   4'd5,     31'd1);
      send_request(FUNC_TO_CODED,   4'd0,     31'd5);
      send_request(FUNC_FROM_CODED, 4'd1,     31'd5);
      send_request(FUNC_TO_CODED,   4'd11,    VALUE_MAX);
      send_request(FUNC_FROM_CODED, 4'd15,    VALUE_MAX);
      send_request(FUNC_TO_CODED,   4'd15,    '0);
      send_request(FUNC_FROM_CODED, 4'd8,     31'd70000000);

      // Random: change the idling mode every hundred items, none at the tail
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 100 == 0) begin
            pick          = $urandom_range(0, 3);
            req_gaps_on   = (k < RANDOM_ITEMS - QUIET_TAIL) && pick[0];
            rsp_stalls_on = (k < RANDOM_ITEMS - QUIET_TAIL) && pick[1];
         end
         pick  = $urandom_range(0, 99);
         func  = 1'($urandom_range(0, 1));
         radix = (pick < 12) ? RADIX_W'($urandom_range(0, 15))
                             : RADIX_W'($urandom_range(RADIX_LO, RADIX_HI));
         value = (func == FUNC_FROM_CODED && pick < 75) ? random_coded(radix)
                                                       : random_binary();
         send_request(func, radix, value);
      end
      req_tvalid <= 1'b0;

      // Drain, then let the pipeline settle
      while (board.pending_conversions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending_conversions.size() != 0) begin
         $error("%0d results never arrived", board.pending_conversions.size());
         board.failures++;
      end
      if (board.failures == 0)
         $display("decimal_coded_radix_converter: match");
      else
         $display("decimal_coded_radix_converter: mismatch");
      $finish;
   end

endmodule
